// File: src/gvn_pkg.sv
`default_nettype none
package gvn_pkg;

  localparam int MAX_COLUMNS_DEF = 256;
  localparam int COORD_BITS_DEF  = 16;
  localparam int ROW_W           = 12;
  localparam int OCOL_W          = 8;
  localparam int CFG_ROWS_W      = 13;
  localparam int CFG_COLS_W      = 9;
  localparam int CFG_W           = 13;
  localparam int NUM_TERMS       = 6;
  localparam int SQRT_STEPS      = 32;
  localparam int DIV_STEPS       = 15;

  typedef enum logic {
    CFG_GRID_ROWS    = 1'b0,
    CFG_GRID_COLUMNS = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEL, ST_TERM, ST_NSTART, ST_NORM, ST_SQ, ST_SQRT, ST_DIV, ST_OUT, ST_ADV
  } ctrl_state_e;

  typedef enum logic [3:0] {
    DP_NOP, DP_CLEAR, DP_LOAD_PT, DP_DIFF, DP_MUL, DP_NORM_START, DP_NORM_STEP, DP_SQ,
    DP_SQRT_INIT, DP_SQRT_STEP, DP_DIV_INIT, DP_DIV_STEP, DP_DIV_END, DP_OUT_LOAD
  } dp_op_e;

  typedef enum logic [1:0] {ROW_UP, ROW_MID, ROW_DN} row_sel_e;
  typedef enum logic [1:0] {COL_LEFT, COL_SAME, COL_RIGHT} col_off_e;

  // slots of a triangle term: 0 = a tip, 1 = b tip, 2 = shared corner
  localparam logic [1:0] SLOT_A = 2'd0;
  localparam logic [1:0] SLOT_B = 2'd1;
  localparam logic [1:0] SLOT_Q = 2'd2;

  typedef struct packed {
    dp_op_e            op;
    logic [1:0]        slot;
    logic [2:0]        idx;
    logic              term_en;
    logic [ROW_W-1:0]  row;
    logic [OCOL_W-1:0] col;
    logic              last;
  } dp_cmd_t;

  typedef struct packed {
    logic zero;
    logic norm_ok;
    logic out_free;
  } dp_stat_t;

  // neighbor point ids 1..7 around a vertex (4 is the vertex itself)
  function automatic logic [2:0] term_pt(logic [2:0] term, logic [1:0] slot);
    logic [2:0] a, b, q;
    case (term)
      3'd0:    begin a = 3'd3; b = 3'd1; q = 3'd4; end
      3'd1:    begin a = 3'd2; b = 3'd4; q = 3'd1; end
      3'd2:    begin a = 3'd4; b = 3'd2; q = 3'd5; end
      3'd3:    begin a = 3'd4; b = 3'd6; q = 3'd3; end
      3'd4:    begin a = 3'd6; b = 3'd4; q = 3'd7; end
      default: begin a = 3'd5; b = 3'd7; q = 3'd4; end
    endcase
    case (slot)
      SLOT_A:  return a;
      SLOT_B:  return b;
      default: return q;
    endcase
  endfunction

  function automatic row_sel_e pt_row(logic [2:0] id);
    case (id)
      3'd1, 3'd2:       return ROW_UP;
      3'd3, 3'd4, 3'd5: return ROW_MID;
      default:          return ROW_DN;
    endcase
  endfunction

  function automatic col_off_e pt_col(logic [2:0] id);
    case (id)
      3'd3, 3'd6: return COL_LEFT;
      3'd2, 3'd5: return COL_RIGHT;
      default:    return COL_SAME;
    endcase
  endfunction

  function automatic logic [1:0] bank_prev(logic [1:0] b);
    return (b == 2'd0) ? 2'd2 : b - 2'd1;
  endfunction

  function automatic logic [1:0] bank_next(logic [1:0] b);
    return (b == 2'd2) ? 2'd0 : b + 2'd1;
  endfunction

endpackage
`default_nettype wire

// File: src/gvn_line_store.sv
`default_nettype none
module gvn_line_store
  import gvn_pkg::*;
#(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF,
  localparam int ADDR_W = $clog2(3 * MAX_COLUMNS),
  localparam int DATA_W = 3 * COORD_BITS
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [DATA_W-1:0] wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output logic      [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem_q [3 * MAX_COLUMNS];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule
`default_nettype wire

// File: src/gvn_ctrl.sv
`default_nettype none
module gvn_ctrl
  import gvn_pkg::*;
#(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  localparam int ADDR_W = $clog2(3 * MAX_COLUMNS),
  localparam int COL_W  = $clog2(MAX_COLUMNS)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_index_i,
  input  wire logic [CFG_W-1:0]  cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   wr_en_o,
  output logic      [ADDR_W-1:0] wr_addr_o,
  output logic                   rd_en_o,
  output logic      [ADDR_W-1:0] rd_addr_o,
  output dp_cmd_t                cmd_o,
  input  dp_stat_t               stat_i
);

  ctrl_state_e state_q, state_d;
  logic [4:0]            cnt_q, cnt_d;
  logic [2:0]            term_q, term_d;
  logic [1:0]            ek_q, ek_d;
  logic [ROW_W-1:0]      row_q, row_d;
  logic [COL_W-1:0]      col_q, col_d;
  logic [1:0]            bank_q, bank_d;
  logic [CFG_ROWS_W-1:0] rows_q;
  logic [CFG_COLS_W-1:0] cols_q;

  logic [ROW_W-1:0] last_row;
  logic [COL_W-1:0] last_col;
  logic [31:0]      cols32;
  logic             e_en, e_last;
  logic [ROW_W-1:0] er;
  logic [COL_W-1:0] ec, pcol;
  logic [1:0]       eb, pbank;
  logic             ig, il, jg, jl, t_en;
  logic [2:0]       pid;
  logic             accept;

  always_comb begin
    if (rows_q < CFG_ROWS_W'(2)) last_row = ROW_W'(1);
    else if (rows_q > CFG_ROWS_W'(4096)) last_row = ROW_W'(4095);
    else last_row = ROW_W'(rows_q - CFG_ROWS_W'(1));
    cols32 = 32'(cols_q);
    if (cols32 < 32'd2) last_col = COL_W'(1);
    else if (cols32 > 32'(MAX_COLUMNS)) last_col = COL_W'(MAX_COLUMNS - 1);
    else last_col = COL_W'(cols32 - 32'd1);
  end

  // emission k: above row at same column, then bottom-row left and last-column own vertex
  always_comb begin
    e_last = 1'b0;
    case (ek_q)
      2'd0: begin
        e_en = (row_q != '0);
        er = row_q - ROW_W'(1); ec = col_q; eb = bank_prev(bank_q);
      end
      2'd1: begin
        e_en = (row_q == last_row) && (col_q != '0);
        er = row_q; ec = col_q - COL_W'(1); eb = bank_q;
      end
      default: begin
        e_en = (row_q == last_row) && (col_q == last_col);
        er = row_q; ec = col_q; eb = bank_q; e_last = 1'b1;
      end
    endcase
    ig = (er != '0);
    il = (er != last_row);
    jg = (ec != '0);
    jl = (ec != last_col);
    case (term_q)
      3'd0:       t_en = ig & jg;
      3'd1, 3'd2: t_en = ig & jl;
      3'd3, 3'd4: t_en = il & jg;
      default:    t_en = il & jl;
    endcase
    pid = term_pt(term_q, cnt_q[1:0]);
    case (pt_row(pid))
      ROW_UP:  pbank = bank_prev(eb);
      ROW_MID: pbank = eb;
      default: pbank = bank_next(eb);
    endcase
    case (pt_col(pid))
      COL_LEFT:  pcol = ec - COL_W'(1);
      COL_RIGHT: pcol = ec + COL_W'(1);
      default:   pcol = ec;
    endcase
  end

  assign accept    = (state_q == ST_IDLE) && in_valid_i;
  assign in_ready_o = (state_q == ST_IDLE);
  assign wr_en_o   = accept;
  assign wr_addr_o = ADDR_W'(bank_q) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(col_q);
  assign rd_addr_o = ADDR_W'(pbank) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(pcol);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q + 5'd1;
    term_d  = term_q;
    ek_d    = ek_q;
    row_d   = row_q;
    col_d   = col_q;
    bank_d  = bank_q;
    rd_en_o = 1'b0;
    cmd_o.op      = DP_NOP;
    cmd_o.slot    = cnt_q[1:0] - 2'd1;
    cmd_o.idx     = cnt_q[2:0];
    cmd_o.term_en = t_en;
    cmd_o.row     = er;
    cmd_o.col     = OCOL_W'(32'(ec));
    cmd_o.last    = e_last;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        ek_d  = '0;
        if (accept) state_d = ST_SEL;
      end
      ST_SEL: begin
        cnt_d  = '0;
        term_d = '0;
        if (e_en) begin
          cmd_o.op = DP_CLEAR;
          state_d  = ST_TERM;
        end else if (ek_q == 2'd2) begin
          state_d = ST_ADV;
        end else begin
          ek_d = ek_q + 2'd1;
        end
      end
      ST_TERM: begin
        rd_en_o = (cnt_q < 5'd3);
        if (cnt_q >= 5'd1 && cnt_q <= 5'd3) cmd_o.op = DP_LOAD_PT;
        else if (cnt_q == 5'd4) cmd_o.op = DP_DIFF;
        else if (cnt_q >= 5'd5 && cnt_q <= 5'd10) begin
          cmd_o.op  = DP_MUL;
          cmd_o.idx = 3'(cnt_q - 5'd5);
        end
        if (cnt_q == 5'd11) begin
          cnt_d = '0;
          if (term_q == 3'(NUM_TERMS - 1)) state_d = ST_NSTART;
          else term_d = term_q + 3'd1;
        end
      end
      ST_NSTART: begin
        cmd_o.op = DP_NORM_START;
        state_d  = ST_NORM;
      end
      ST_NORM: begin
        cnt_d = '0;
        if (stat_i.zero) state_d = ST_OUT;
        else if (stat_i.norm_ok) state_d = ST_SQ;
        else cmd_o.op = DP_NORM_STEP;
      end
      ST_SQ: begin
        if (cnt_q < 5'd3) cmd_o.op = DP_SQ;
        if (cnt_q == 5'd4) begin
          cmd_o.op = DP_SQRT_INIT;
          cnt_d    = '0;
          state_d  = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd_o.op = DP_SQRT_STEP;
        if (cnt_q == 5'(SQRT_STEPS - 1)) begin
          cnt_d   = '0;
          term_d  = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        // term_q doubles as the component counter here
        cmd_o.idx = term_q;
        if (cnt_q == 5'd0) cmd_o.op = DP_DIV_INIT;
        else if (cnt_q == 5'(DIV_STEPS + 1)) begin
          cmd_o.op = DP_DIV_END;
          cnt_d    = '0;
          if (term_q == 3'd2) state_d = ST_OUT;
          else term_d = term_q + 3'd1;
        end else cmd_o.op = DP_DIV_STEP;
      end
      ST_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.op = DP_OUT_LOAD;
          if (ek_q == 2'd2) state_d = ST_ADV;
          else begin
            ek_d    = ek_q + 2'd1;
            state_d = ST_SEL;
          end
        end
      end
      ST_ADV: begin
        state_d = ST_IDLE;
        if (col_q == last_col) begin
          col_d = '0;
          if (row_q == last_row) begin
            row_d  = '0;
            bank_d = '0;
          end else begin
            row_d  = row_q + ROW_W'(1);
            bank_d = bank_next(bank_q);
          end
        end else begin
          col_d = col_q + COL_W'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (cfg_we_i) begin
      row_d  = '0;
      col_d  = '0;
      bank_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      term_q  <= '0;
      ek_q    <= '0;
      row_q   <= '0;
      col_q   <= '0;
      bank_q  <= '0;
      rows_q  <= CFG_ROWS_W'(2);
      cols_q  <= CFG_COLS_W'(2);
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      term_q  <= term_d;
      ek_q    <= ek_d;
      row_q   <= row_d;
      col_q   <= col_d;
      bank_q  <= bank_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_GRID_ROWS: rows_q <= cfg_data_i[CFG_ROWS_W-1:0];
          default:       cols_q <= cfg_data_i[CFG_COLS_W-1:0];
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// File: src/gvn_datapath.sv
`default_nettype none
module gvn_datapath
  import gvn_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int DATA_W = 3 * COORD_BITS,
  localparam int ACC_W  = 2 * COORD_BITS + 6,
  localparam int MAG_W  = (ACC_W > 31) ? ACC_W : 31,
  localparam int DIV_W  = 47
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  dp_cmd_t                cmd_i,
  output dp_stat_t               stat_o,
  input  wire logic [DATA_W-1:0] rd_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic      [15:0]       normal_x_o,
  output logic      [15:0]       normal_y_o,
  output logic      [15:0]       normal_z_o,
  output logic      [ROW_W-1:0]  vertex_row_o,
  output logic      [OCOL_W-1:0] vertex_col_o,
  output logic                   degenerate_o,
  output logic                   frame_last_o
);

  logic signed [COORD_BITS-1:0] pa_q [3];
  logic signed [COORD_BITS-1:0] pb_q [3];
  logic signed [COORD_BITS-1:0] pq_q [3];
  logic signed [COORD_BITS:0]   da_q [3];
  logic signed [COORD_BITS:0]   db_q [3];
  logic signed [ACC_W-1:0]      acc_q [3];
  logic        [MAG_W-1:0]      mag_q [3];
  logic        [2:0]            pos_q;
  logic        [15:0]           res_q [3];
  logic signed [63:0]           prod_q;
  logic                         prod_v_q, prod_sq_q, prod_neg_q;
  logic        [1:0]            prod_c_q;
  logic        [63:0]           sum_q, rem_q, root_q, bit_q;
  logic        [DIV_W-1:0]      drem_q, dvs_q;
  logic        [DIV_W-1:0]      drem_init;
  logic        [DIV_W-1:0]      dvs_init;
  logic        [DIV_W-1:0]      drem_sub;
  logic        [14:0]           quo_q;
  logic        [15:0]           quo_ext;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic        [1:0]  mul_c;
  logic               mul_neg;
  logic [MAG_W-1:0]   mag_sel, mag_or;
  logic               sel_pos;
  logic [63:0]        trial;
  logic [COORD_BITS-1:0] rx, ry, rz;

  assign rx = rd_data_i[COORD_BITS-1:0];
  assign ry = rd_data_i[2*COORD_BITS-1:COORD_BITS];
  assign rz = rd_data_i[3*COORD_BITS-1:2*COORD_BITS];

  always_comb begin
    case (cmd_i.idx[1:0])
      2'd0:    begin mag_sel = mag_q[0]; sel_pos = pos_q[0]; end
      2'd1:    begin mag_sel = mag_q[1]; sel_pos = pos_q[1]; end
      default: begin mag_sel = mag_q[2]; sel_pos = pos_q[2]; end
    endcase
    mag_or = mag_q[0] | mag_q[1] | mag_q[2];
  end

  // cross product a x b as six signed products, one per cycle
  always_comb begin
    mul_c   = 2'd0;
    mul_neg = 1'b0;
    case (cmd_i.idx)
      3'd0: begin mul_a = 32'(da_q[1]); mul_b = 32'(db_q[2]); mul_c = 2'd0; end
      3'd1: begin mul_a = 32'(da_q[2]); mul_b = 32'(db_q[1]); mul_c = 2'd0; mul_neg = 1'b1; end
      3'd2: begin mul_a = 32'(da_q[2]); mul_b = 32'(db_q[0]); mul_c = 2'd1; end
      3'd3: begin mul_a = 32'(da_q[0]); mul_b = 32'(db_q[2]); mul_c = 2'd1; mul_neg = 1'b1; end
      3'd4: begin mul_a = 32'(da_q[0]); mul_b = 32'(db_q[1]); mul_c = 2'd2; end
      default: begin
        mul_a = 32'(da_q[1]); mul_b = 32'(db_q[0]); mul_c = 2'd2; mul_neg = 1'b1;
      end
    endcase
    if (cmd_i.op == DP_SQ) begin
      mul_a = $signed({2'b00, mag_sel[29:0]});
      mul_b = $signed({2'b00, mag_sel[29:0]});
    end
    mul_p = mul_a * mul_b;
  end

  assign trial     = root_q + bit_q;
  assign drem_init = (DIV_W'(mag_sel[29:0]) << 14) + DIV_W'(root_q[31:1]);
  assign dvs_init  = DIV_W'(root_q[31:0]) << 14;
  assign drem_sub  = drem_q - dvs_q;
  assign quo_ext   = {1'b0, quo_q};

  assign stat_o.zero     = (mag_or == '0);
  assign stat_o.norm_ok  = (mag_or[29] == 1'b1) && ((mag_or >> 30) == '0);
  assign stat_o.out_free = !out_valid_o || out_ready_i;

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_LOAD_PT: begin
        case (cmd_i.slot)
          SLOT_A: begin pa_q[0] <= rx; pa_q[1] <= ry; pa_q[2] <= rz; end
          SLOT_B: begin pb_q[0] <= rx; pb_q[1] <= ry; pb_q[2] <= rz; end
          default: begin pq_q[0] <= rx; pq_q[1] <= ry; pq_q[2] <= rz; end
        endcase
      end
      DP_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          da_q[i] <= cmd_i.term_en ? (COORD_BITS+1)'(pa_q[i]) - (COORD_BITS+1)'(pq_q[i]) : '0;
          db_q[i] <= cmd_i.term_en ? (COORD_BITS+1)'(pb_q[i]) - (COORD_BITS+1)'(pq_q[i]) : '0;
        end
      end
      DP_NORM_START: begin
        for (int i = 0; i < 3; i++) begin
          mag_q[i] <= MAG_W'(acc_q[i][ACC_W-1] ? -acc_q[i] : acc_q[i]);
          pos_q[i] <= !acc_q[i][ACC_W-1] && (acc_q[i] != '0);
        end
      end
      DP_NORM_STEP: begin
        for (int i = 0; i < 3; i++) begin
          mag_q[i] <= (mag_or[29] == 1'b0 && (mag_or >> 30) == '0) ?
                      (mag_q[i] << 1) : (mag_q[i] >> 1);
        end
      end
      DP_SQRT_INIT: begin
        rem_q  <= sum_q;
        root_q <= '0;
        bit_q  <= 64'd1 << 62;
      end
      DP_SQRT_STEP: begin
        if (rem_q >= trial) begin
          rem_q  <= rem_q - trial;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      DP_DIV_INIT: begin
        drem_q <= drem_init;
        dvs_q  <= dvs_init;
        quo_q  <= '0;
      end
      DP_DIV_STEP: begin
        if (drem_q >= dvs_q) begin
          drem_q <= drem_sub;
          quo_q  <= {quo_q[13:0], 1'b1};
        end else begin
          quo_q  <= {quo_q[13:0], 1'b0};
        end
        dvs_q <= dvs_q >> 1;
      end
      DP_DIV_END: begin
        case (cmd_i.idx[1:0])
          2'd0:    res_q[0] <= sel_pos ? -quo_ext : quo_ext;
          2'd1:    res_q[1] <= sel_pos ? -quo_ext : quo_ext;
          default: res_q[2] <= sel_pos ? -quo_ext : quo_ext;
        endcase
      end
      default: ;
    endcase
    if (cmd_i.op == DP_MUL || cmd_i.op == DP_SQ) begin
      prod_q     <= mul_p;
      prod_sq_q  <= (cmd_i.op == DP_SQ);
      prod_c_q   <= mul_c;
      prod_neg_q <= mul_neg;
    end
    if (cmd_i.op == DP_OUT_LOAD) begin
      normal_x_o   <= stat_o.zero ? '0 : res_q[0];
      normal_y_o   <= stat_o.zero ? '0 : res_q[1];
      normal_z_o   <= stat_o.zero ? '0 : res_q[2];
      vertex_row_o <= cmd_i.row;
      vertex_col_o <= cmd_i.col;
      degenerate_o <= stat_o.zero;
      frame_last_o <= cmd_i.last;
    end
  end

  // accumulate the product registered in the previous cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q    <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      prod_v_q <= (cmd_i.op == DP_MUL) || (cmd_i.op == DP_SQ);
      if (cmd_i.op == DP_OUT_LOAD) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_CLEAR) begin
      for (int i = 0; i < 3; i++) acc_q[i] <= '0;
    end else if (prod_v_q && !prod_sq_q) begin
      case (prod_c_q)
        2'd0: acc_q[0] <= prod_neg_q ? acc_q[0] - prod_q[ACC_W-1:0]
                                     : acc_q[0] + prod_q[ACC_W-1:0];
        2'd1: acc_q[1] <= prod_neg_q ? acc_q[1] - prod_q[ACC_W-1:0]
                                     : acc_q[1] + prod_q[ACC_W-1:0];
        default: acc_q[2] <= prod_neg_q ? acc_q[2] - prod_q[ACC_W-1:0]
                                        : acc_q[2] + prod_q[ACC_W-1:0];
      endcase
    end
    if (cmd_i.op == DP_NORM_START) begin
      sum_q <= '0;
    end else if (prod_v_q && prod_sq_q) begin
      sum_q <= sum_q + 64'(prod_q);
    end
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == DP_OUT_LOAD |-> stat_o.out_free)
    else $error("result loaded over a word not yet taken");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == DP_OUT_LOAD |=> out_valid_o)
    else $error("loaded result not presented");

  a_sqrt_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.op) == DP_SQRT_STEP |-> $onehot0(bit_q))
    else $error("square root bit lost its single-bit form");

endmodule
`default_nettype wire

// File: src/grid_vertex_normal_stream.sv
`default_nettype none
// Cloth grid vertex normals. Vertex positions enter in raster order. Each vertex writes a
// three-row line store and triggers the normal of the vertex above it. On the bottom row it
// also triggers the normals of that row.
// A vertex passes through its own states: accept, a select state for each of its three possible
// normals, and advance. Each normal it triggers (up to three) adds the steps below; a zero sum
// goes from the scale search straight to the output:
//   - the six triangles are re-read from the single read port of the line store, one after
//     another, on one shared multiplier;
//   - a scale search, one shift per step (up to 29 shifts);
//   - three squares and a 32-step square root;
//   - three passes of a 15-step divider.
// A normal also waits while the previous word is still held in the output register.
// An input word is taken only while no normal is being worked on. A finished normal waits in
// an output register so the next vertex can enter. A configuration write restarts the frame
// at row 0, column 0.
module grid_vertex_normal_stream
  import gvn_pkg::*;
#(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF,
  localparam int ADDR_W = $clog2(3 * MAX_COLUMNS),
  localparam int DATA_W = 3 * COORD_BITS
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_index_i,
  input  wire logic [CFG_W-1:0] cfg_data_i,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [47:0]      s_axis_tdata,   // pos_x, pos_y, pos_z
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic      [71:0]      m_axis_tdata,   // normal_x, normal_y, normal_z, vertex_row,
                                                // vertex_col, zero pad
  output logic                  m_axis_tuser,   // degenerate
  output logic                  m_axis_tlast    // frame_last
);

  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [DATA_W-1:0] wr_data, rd_data;
  logic [15:0]       nx, ny, nz;
  logic [ROW_W-1:0]  vrow;
  logic [OCOL_W-1:0] vcol;
  logic [31:0]       ex, ey, ez;

  assign ex = 32'(s_axis_tdata[15:0]);
  assign ey = 32'(s_axis_tdata[31:16]);
  assign ez = 32'(s_axis_tdata[47:32]);
  assign wr_data = {ez[COORD_BITS-1:0], ey[COORD_BITS-1:0], ex[COORD_BITS-1:0]};

  gvn_ctrl #(.MAX_COLUMNS(MAX_COLUMNS)) u_ctrl (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  gvn_line_store #(.MAX_COLUMNS(MAX_COLUMNS), .COORD_BITS(COORD_BITS)) u_store (
    .clk_i,
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  gvn_datapath #(.COORD_BITS(COORD_BITS)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i        (cmd),
    .stat_o       (stat),
    .rd_data_i    (rd_data),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .normal_x_o   (nx),
    .normal_y_o   (ny),
    .normal_z_o   (nz),
    .vertex_row_o (vrow),
    .vertex_col_o (vcol),
    .degenerate_o (m_axis_tuser),
    .frame_last_o (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0, vcol, vrow, nz, ny, nx};

endmodule
`default_nettype wire
